// ===== design/tla_pkg.sv =====
// ----------------------------------------------------------------------------
// tla_pkg
// shared constants for the toroidal life automaton core
// ----------------------------------------------------------------------------
package tla_pkg;

  localparam int BOARD_SIZE = 8;
  localparam int ROW_W      = $clog2(BOARD_SIZE);
  localparam int LIMIT_W    = 12;
  localparam int GEN_W      = 13;
  localparam int CNT_W      = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(BOARD_SIZE * BOARD_SIZE);

  localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_CNT = CNT_W'(2);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef logic [BOARD_SIZE-1:0] row_t;

endpackage

// ===== design/tla_row_unit.sv =====
// ----------------------------------------------------------------------------
// tla_row_unit
// next-generation rule for one board row from its two wrapped neighbors
// ----------------------------------------------------------------------------
module tla_row_unit
  import tla_pkg::*;
(
  input  row_t up_i,
  input  row_t cur_i,
  input  row_t dn_i,
  output row_t nxt_o
);

  always_comb begin
    logic [ROW_W-1:0] lf;
    logic [ROW_W-1:0] rt;
    logic [CNT_W-1:0] cnt;
    nxt_o = '0;
    for (int c = 0; c < BOARD_SIZE; c++) begin
      // columns wrap around the torus
      lf  = ROW_W'(c + BOARD_SIZE - 1);
      rt  = ROW_W'(c + 1);
      cnt = CNT_W'(up_i[lf]) + CNT_W'(up_i[c]) + CNT_W'(up_i[rt])
          + CNT_W'(cur_i[lf]) + CNT_W'(cur_i[rt])
          + CNT_W'(dn_i[lf]) + CNT_W'(dn_i[c]) + CNT_W'(dn_i[rt]);
      nxt_o[c] = (cnt == BIRTH_CNT) || (cur_i[c] && (cnt == SURVIVE_CNT));
    end
  end

endmodule

// ===== design/toroidal_life_automaton_core.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_automaton_core
// 8x8 game of life on a torus, row loads and generation steps over streams
// ----------------------------------------------------------------------------
// usage:
//   slave stream: tuser = cmd (0 load, 1 step); tdata = row_select[2:0],
//   row_cells[10:3]. a load word writes one board row and gives
//   no output. a step word computes the next generation one row per cycle
//   on a shared row unit, decides in the update state whether the board
//   is stable or the generation limit is passed, then emits the 8 board rows
//   on the master stream, row 0 first, tlast on row 7, tuser = finished.
//   after the step word is taken the block steps through calc, update and
//   emit, ready again once the last row enters the output register; the
//   row unit loop runs one row a cycle, board rotating past fixed taps.
//   s_axis_tready is high only while no step is in progress.
//   when the receiver stalls, the emit sequence waits on the output register;
//   the last row may still sit there while the next word is taken.
//   cfg channel writes generation_limit (12 bits); write it only while idle,
//   which the block itself does not enforce; cfg_ready_o is always high.
//   reset: board all dead, generation 0, limit 64, no output pending.
// ----------------------------------------------------------------------------
module toroidal_life_automaton_core
  import tla_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,      // generation_limit
  // command stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,    // row_select[2:0], row_cells[10:3], zero pad
  input  logic               s_axis_tuser,    // cmd
  // board row stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,    // out_row[2:0], out_cells[10:3], generation_count[23:11]
  output logic               m_axis_tlast,    // last_row
  output logic               m_axis_tuser     // finished
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e             state_q;
  row_t               board_q [BOARD_SIZE];
  row_t               nxt_q   [BOARD_SIZE];
  logic [ROW_W-1:0]   cnt_q;
  logic               same_q;
  logic               fin_q;
  logic [GEN_W-1:0]   gen_q;
  logic [LIMIT_W-1:0] limit_q;

  // output register
  logic               out_vld_q;
  logic [ROW_W-1:0]   out_row_q;
  row_t               out_cells_q;
  logic               out_last_q;
  logic               out_fin_q;
  logic [GEN_W-1:0]   out_gen_q;

  row_t               row_nxt;
  logic               s_acc;
  logic               out_free;
  logic               emit_go;
  logic               done;
  logic [ROW_W-1:0]   sel_row;
  row_t               sel_cells;

  // board rotates so the current row always sits at entry 0
  tla_row_unit u_row (
    .up_i  (board_q[BOARD_SIZE-1]),
    .cur_i (board_q[0]),
    .dn_i  (board_q[1]),
    .nxt_o (row_nxt)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign sel_row       = s_axis_tdata[ROW_W-1:0];
  assign sel_cells     = s_axis_tdata[ROW_W +: BOARD_SIZE];
  assign out_free      = !out_vld_q || m_axis_tready;
  // next board row goes into the output register this cycle
  assign emit_go       = (state_q == ST_EMIT) && out_free;
  // stable board, or count already past the limit
  assign done          = same_q || (gen_q > {1'b0, limit_q});

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_gen_q, out_cells_q, out_row_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      same_q    <= 1'b1;
      fin_q     <= 1'b0;
      gen_q     <= '0;
      limit_q   <= LIMIT_RESET;
      out_vld_q <= 1'b0;
      for (int i = 0; i < BOARD_SIZE; i++) begin
        board_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      // a new row replaces the one leaving, otherwise a taken row clears
      if (emit_go) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser == CMD_LOAD) begin
              board_q[sel_row] <= sel_cells;
            end else begin
              cnt_q   <= '0;
              same_q  <= 1'b1;
              state_q <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          // new row enters the top of the next-board shift line
          nxt_q[BOARD_SIZE-1] <= row_nxt;
          for (int i = 0; i < BOARD_SIZE - 1; i++) begin
            nxt_q[i] <= nxt_q[i+1];
          end
          for (int i = 0; i < BOARD_SIZE; i++) begin
            board_q[i] <= board_q[ROW_W'(i + 1)];
          end
          if (row_nxt != board_q[0]) begin
            same_q <= 1'b0;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ROW_W'(BOARD_SIZE - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          fin_q <= done;
          if (done) begin
            gen_q <= '0;
          end else begin
            gen_q <= gen_q + 1'b1;
            for (int i = 0; i < BOARD_SIZE; i++) begin
              board_q[i] <= nxt_q[i];
            end
          end
          cnt_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_row_q   <= cnt_q;
            out_cells_q <= board_q[0];
            out_last_q  <= (cnt_q == ROW_W'(BOARD_SIZE - 1));
            out_fin_q   <= fin_q;
            out_gen_q   <= gen_q;
            for (int i = 0; i < BOARD_SIZE; i++) begin
              board_q[i] <= board_q[ROW_W'(i + 1)];
            end
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == ROW_W'(BOARD_SIZE - 1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a finished step always reports a cleared count
  a_fin_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[23:11] == '0))
    else $error("finished row with nonzero generation count");

  // tlast marks exactly the final board row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[ROW_W-1:0] == ROW_W'(BOARD_SIZE - 1))))
    else $error("tlast does not match the final row");

  // a taken step blocks further commands
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_STEP)) |=> !s_axis_tready)
    else $error("ready during a step");

  // rows leave in order
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tdata[ROW_W-1:0] == ROW_W'($past(m_axis_tdata[ROW_W-1:0]) + 1)))
      || !m_axis_tvalid)
    else $error("board rows out of order");
`endif

endmodule
